FILE: hw/rtl/chunk_receipt_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Chunk receipt tracker assertion macros
// Short forms for the concurrent checks of the tracker core.
// ----------------------------------------------------------------------------
`ifndef CHUNK_RECEIPT_TRACKER_CORE_MACROS_SVH
`define CHUNK_RECEIPT_TRACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// Chunk receipt tracker package
// Sizes, codes and shared types of the chunk receipt tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MAX_CHUNKS  = 16384;
  localparam int CHUNK_BYTES = 1024;
  localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int MAP_WORDS   = MAX_CHUNKS / WORD_BITS;
  localparam int WADDR_W     = $clog2(MAP_WORDS);
  localparam int SLOT_W      = $clog2(MAX_CHUNKS);
  localparam int COUNT_W     = SLOT_W + 1;
  localparam int ADDR_W      = 32;
  localparam int TB_W        = 25;
  localparam int LEN_W       = 11;

  localparam logic [TB_W-1:0] MAP_BYTES = TB_W'(MAX_CHUNKS * CHUNK_BYTES);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_PART  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PART_RD,
    S_PART_WR,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    word_t              wr_data;
    logic [WADDR_W-1:0] rd_addr;
  } map_req_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

endpackage

FILE: hw/rtl/crt_map.sv
// ----------------------------------------------------------------------------
// Chunk receipt map
// Bit map of received chunks, one word written and one word read per cycle.
// ----------------------------------------------------------------------------
module crt_map (
  input  logic              clk,
  input  crt_pkg::map_req_t req,
  output crt_pkg::word_t    rd_data
);
  import crt_pkg::*;

  word_t mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

FILE: hw/rtl/crt_scan.sv
// ----------------------------------------------------------------------------
// Chunk receipt scan unit
// Finds the lowest missing chunk in one map word, ignoring bits past the end.
// ----------------------------------------------------------------------------
module crt_scan (
  input  crt_pkg::word_t               word,
  input  logic                         is_last,
  input  logic [crt_pkg::BIT_W-1:0]    last_bit,
  output crt_pkg::scan_res_t           res
);
  import crt_pkg::*;

  word_t masked;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      masked[b] = word[b] | (is_last && (BIT_W'(b) > last_bit));
    end
  end

  always_comb begin
    res.hit = ~&masked;
    res.pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        res.pos = BIT_W'(b);
      end
    end
  end

endmodule

FILE: hw/rtl/chunk_receipt_tracker_core.sv
// ----------------------------------------------------------------------------
// Chunk receipt tracker core
// Records received 1 KiB chunks of a download and reports the first missing
// chunk of the transfer on request.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals
//  in       input      in_valid, in_stall, action, address, total_bytes
//  out      output     out_valid, out_stall, missing_address, missing_bytes,
//                      complete
//
// A start request clears all 512 map words before the next request is taken.
// A chunk request reads, modifies and writes one map word in S_PART_RD and
// S_PART_WR; a chunk outside the map leaves the map untouched.
// A query reads the map one 32-bit word per cycle in S_SCAN up to the word
// of the last chunk or the first word with a missing chunk, then emits in
// S_EMIT; a query of an empty transfer goes straight to S_EMIT.
// After reset all 512 map words are cleared before the first request.
// A stalled result waits in the output register; a query that finishes
// while it still waits holds until the output register is free.
// ----------------------------------------------------------------------------
`include "chunk_receipt_tracker_core_macros.svh"

module chunk_receipt_tracker_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [crt_pkg::ADDR_W-1:0]   address,
  input  logic [crt_pkg::TB_W-1:0]     total_bytes,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [crt_pkg::ADDR_W-1:0]   missing_address,
  output logic [crt_pkg::LEN_W-1:0]    missing_bytes,
  output logic                         complete
);
  import crt_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [WADDR_W-1:0]       clr_addr;
  logic [ADDR_W-1:0]        base_address;
  logic                     empty;
  logic [SLOT_W-1:0]        last_idx;
  logic [CHUNK_SHIFT-1:0]   rem_bytes;
  logic [SLOT_W-1:0]        part_slot;
  logic [WADDR_W-1:0]       rd_addr;
  logic                     chk_valid;
  logic [WADDR_W-1:0]       chk_addr;
  logic [SLOT_W-1:0]        fnd_idx;
  logic                     fnd_complete;

  logic                     accept;
  logic                     out_free;
  logic [TB_W-1:0]          capped;
  logic [TB_W:0]            round_sum;
  logic [COUNT_W-1:0]       count;
  logic [ADDR_W-1:0]        diff;
  logic                     in_range;
  logic                     is_last;
  map_req_t                 map_req;
  word_t                    rd_data;
  scan_res_t                scan_res;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign capped    = (total_bytes > MAP_BYTES) ? MAP_BYTES : total_bytes;
  assign round_sum = {1'b0, capped} + (TB_W + 1)'(CHUNK_BYTES - 1);
  assign count     = COUNT_W'(round_sum >> CHUNK_SHIFT);

  assign diff     = address - base_address;
  assign in_range = (diff >> (CHUNK_SHIFT + SLOT_W)) == '0;

  assign is_last = chk_addr == last_idx[SLOT_W-1:BIT_W];

  crt_map u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (rd_data)
  );

  crt_scan u_scan (
    .word     (rd_data),
    .is_last  (is_last),
    .last_bit (last_idx[BIT_W-1:0]),
    .res      (scan_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == WADDR_W'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_START: state_next = S_CLEAR;
            ACT_PART:  state_next = in_range ? S_PART_RD : S_IDLE;
            ACT_QUERY: state_next = empty ? S_EMIT : S_SCAN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_PART_RD: state_next = S_PART_WR;
      S_PART_WR: state_next = S_IDLE;
      S_SCAN: begin
        if (chk_valid && (scan_res.hit || is_last)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = state != S_IDLE;
    map_req.wr_en   = 1'b0;
    map_req.wr_addr = clr_addr;
    map_req.wr_data = '0;
    map_req.rd_addr = rd_addr;
    case (state)
      S_CLEAR: begin
        map_req.wr_en = 1'b1;
      end
      S_PART_RD: begin
        map_req.rd_addr = part_slot[SLOT_W-1:BIT_W];
      end
      S_PART_WR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = part_slot[SLOT_W-1:BIT_W];
        map_req.wr_data = rd_data | (WORD_BITS'(1) << part_slot[BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      chk_valid    <= 1'b0;
      out_valid    <= 1'b0;
      base_address <= '0;
      empty        <= 1'b1;
      last_idx     <= '0;
      rem_bytes    <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_START: begin
                base_address <= address;
                empty        <= capped == '0;
                last_idx     <= SLOT_W'(count - 1'b1);
                rem_bytes    <= capped[CHUNK_SHIFT-1:0];
                clr_addr     <= '0;
              end
              ACT_PART: begin
                part_slot <= diff[CHUNK_SHIFT +: SLOT_W];
              end
              ACT_QUERY: begin
                fnd_complete <= empty;
                rd_addr      <= '0;
                chk_valid    <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_valid <= 1'b1;
          chk_addr  <= rd_addr;
          rd_addr   <= rd_addr + 1'b1;
          if (chk_valid && scan_res.hit) begin
            fnd_idx      <= {chk_addr, scan_res.pos};
            fnd_complete <= 1'b0;
          end else if (chk_valid && is_last) begin
            fnd_complete <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (fnd_complete) begin
              missing_address <= '0;
              missing_bytes   <= '0;
              complete        <= 1'b1;
            end else begin
              missing_address <= base_address + (ADDR_W'(fnd_idx) << CHUNK_SHIFT);
              if (fnd_idx == last_idx && rem_bytes != '0) begin
                missing_bytes <= LEN_W'(rem_bytes);
              end else begin
                missing_bytes <= LEN_W'(CHUNK_BYTES);
              end
              complete <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `CRT_ASSERT_SAME(a_complete_zero, out_valid && complete,
    missing_address == '0 && missing_bytes == '0, "complete result with nonzero fields")

  `CRT_ASSERT_SAME(a_length_range, out_valid && !complete,
    missing_bytes != '0 && missing_bytes <= LEN_W'(CHUNK_BYTES),
    "missing chunk length out of range")

  `CRT_ASSERT_NEXT(a_query_busy, accept && action == ACT_QUERY,
    state == S_SCAN || state == S_EMIT, "query request did not start a scan")

  `CRT_ASSERT_NEXT(a_emit_hold, state == S_EMIT && out_valid && out_stall,
    state == S_EMIT, "result dropped while output register was full")

endmodule
